### design/tda_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and controller state codes for the
// three-axis decimating averager. No dependencies.
package tda_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 12;

  // history pointer and window/hop register widths
  localparam int PTR_BITS   = $clog2(WINDOW_MAX);
  localparam int LEN_BITS   = 5;
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEN = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOP_LEN    = CFG_INDEX_BITS'(1);

  localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = LEN_BITS'(4);
  localparam logic [LEN_BITS-1:0] HOP_LEN_RESET    = LEN_BITS'(2);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] z;
  } entry_t;

endpackage

### design/three_axis_decimating_averager.sv
`timescale 1ns / 1ps
// Three-axis decimating averager. A tick that completes a hop runs through accept in ST_IDLE,
// window reads in ST_SUM (one memory read per cycle), ST_DRAIN, 16 divider steps in ST_DIV and
// the result load in ST_DONE, which waits while the result is stalled. The next request is taken
// once the block is back in ST_IDLE. Ticks that complete no hop only advance the hop count.
// Sync reset clears history valid bits, pointer, hop count and registers. Uses tda_pkg.
module three_axis_decimating_averager (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [tda_pkg::SAMPLE_BITS-1:0]     sample_x,
  input  logic [tda_pkg::SAMPLE_BITS-1:0]     sample_y,
  input  logic [tda_pkg::SAMPLE_BITS-1:0]     sample_z,
  output logic                                mean_valid,
  input  logic                                mean_stall,
  output logic [tda_pkg::SAMPLE_BITS-1:0]     mean_x,
  output logic [tda_pkg::SAMPLE_BITS-1:0]     mean_y,
  output logic [tda_pkg::SAMPLE_BITS-1:0]     mean_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tda_pkg::LEN_BITS-1:0]        cfg_data
);

  localparam int SB = tda_pkg::SAMPLE_BITS;
  localparam int LB = tda_pkg::LEN_BITS;
  localparam int PB = tda_pkg::PTR_BITS;
  localparam int UB = tda_pkg::SUM_BITS;
  localparam int KB = tda_pkg::STEP_BITS;

  tda_pkg::state_t state;

  logic [LB-1:0] window_len;
  logic [LB-1:0] hop_len;
  logic [LB-1:0] win_eff;
  logic [LB-1:0] hop_eff;
  logic [LB-1:0] win_lat;

  logic [PB-1:0] write_position;
  logic [PB-1:0] hop_count;
  logic [LB-1:0] hop_count_next;
  logic [PB-1:0] rd_ptr;
  logic [LB-1:0] rd_left;
  logic          rd_live;
  logic          rd_ok;
  logic [KB-1:0] div_cnt;

  tda_pkg::entry_t mem [tda_pkg::WINDOW_MAX];
  logic [tda_pkg::WINDOW_MAX-1:0] vld;
  tda_pkg::entry_t rd_q;

  logic [UB-1:0] sum_x, sum_y, sum_z;
  logic [LB-1:0] rem_x, rem_y, rem_z;
  logic [LB:0]   trial_x, trial_y, trial_z;
  logic          qb_x, qb_y, qb_z;

  logic accept;
  logic out_free;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != tda_pkg::ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !mean_valid || !mean_stall;

  // clamp window to 1..WINDOW_MAX, hop to 1..window
  always_comb begin
    if (window_len == '0) begin
      win_eff = LB'(1);
    end else if (window_len > LB'(tda_pkg::WINDOW_MAX)) begin
      win_eff = LB'(tda_pkg::WINDOW_MAX);
    end else begin
      win_eff = window_len;
    end
    if (hop_len == '0) begin
      hop_eff = LB'(1);
    end else if (hop_len > win_eff) begin
      hop_eff = win_eff;
    end else begin
      hop_eff = hop_len;
    end
  end

  assign hop_count_next = LB'(hop_count) + LB'(1);

  // restoring divider step, one quotient bit per axis per cycle
  assign trial_x = {rem_x, sum_x[UB-1]};
  assign trial_y = {rem_y, sum_y[UB-1]};
  assign trial_z = {rem_z, sum_z[UB-1]};
  assign qb_x    = (trial_x >= {1'b0, win_lat});
  assign qb_y    = (trial_y >= {1'b0, win_lat});
  assign qb_z    = (trial_z >= {1'b0, win_lat});

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= tda_pkg::WINDOW_LEN_RESET;
      hop_len    <= tda_pkg::HOP_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tda_pkg::CFG_WINDOW_LEN: window_len <= cfg_data;
        tda_pkg::CFG_HOP_LEN:    hop_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // history memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[write_position] <= '{x: sample_x, y: sample_y, z: sample_z};
    end
    rd_q <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept) begin
      vld[write_position] <= 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tda_pkg::ST_IDLE;
      write_position <= '0;
      hop_count      <= '0;
      rd_live        <= 1'b0;
      rd_left        <= '0;
      rd_ptr         <= '0;
      div_cnt        <= '0;
      mean_valid     <= 1'b0;
    end else begin
      if (mean_valid && !mean_stall && state != tda_pkg::ST_DONE) begin
        mean_valid <= 1'b0;
      end
      rd_live <= (state == tda_pkg::ST_SUM);
      case (state)
        tda_pkg::ST_IDLE: begin
          if (accept) begin
            write_position <= write_position + PB'(1);
            if (hop_count_next < hop_eff) begin
              hop_count <= hop_count_next[PB-1:0];
            end else begin
              hop_count <= '0;
              rd_ptr    <= write_position;  // newest sample first
              rd_left   <= win_eff;
              state     <= tda_pkg::ST_SUM;
            end
          end
        end
        tda_pkg::ST_SUM: begin
          rd_ptr  <= rd_ptr - PB'(1);
          rd_left <= rd_left - LB'(1);
          if (rd_left == LB'(1)) begin
            state <= tda_pkg::ST_DRAIN;
          end
        end
        tda_pkg::ST_DRAIN: begin
          div_cnt <= KB'(UB - 1);
          state   <= tda_pkg::ST_DIV;
        end
        tda_pkg::ST_DIV: begin
          div_cnt <= div_cnt - KB'(1);
          if (div_cnt == '0) begin
            state <= tda_pkg::ST_DONE;
          end
        end
        tda_pkg::ST_DONE: begin
          if (out_free) begin
            mean_valid <= 1'b1;
            state      <= tda_pkg::ST_IDLE;
          end
        end
        default: state <= tda_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath: window sums, divider, result register
  always_ff @(posedge clk) begin
    rd_ok <= vld[rd_ptr];
    if (accept) begin
      win_lat <= win_eff;
      sum_x   <= '0;
      sum_y   <= '0;
      sum_z   <= '0;
    end else if (rd_live) begin
      if (rd_ok) begin
        sum_x <= sum_x + UB'(rd_q.x);
        sum_y <= sum_y + UB'(rd_q.y);
        sum_z <= sum_z + UB'(rd_q.z);
      end
    end else if (state == tda_pkg::ST_DIV) begin
      // sums shift out the dividend and collect the quotient
      sum_x <= {sum_x[UB-2:0], qb_x};
      sum_y <= {sum_y[UB-2:0], qb_y};
      sum_z <= {sum_z[UB-2:0], qb_z};
    end

    if (state == tda_pkg::ST_DRAIN) begin
      rem_x <= '0;
      rem_y <= '0;
      rem_z <= '0;
    end else if (state == tda_pkg::ST_DIV) begin
      rem_x <= qb_x ? LB'(trial_x - {1'b0, win_lat}) : trial_x[LB-1:0];
      rem_y <= qb_y ? LB'(trial_y - {1'b0, win_lat}) : trial_y[LB-1:0];
      rem_z <= qb_z ? LB'(trial_z - {1'b0, win_lat}) : trial_z[LB-1:0];
    end

    if (state == tda_pkg::ST_DONE && out_free) begin
      mean_x <= sum_x[SB-1:0];
      mean_y <= sum_y[SB-1:0];
      mean_z <= sum_z[SB-1:0];
    end
  end

endmodule

### test/tb_three_axis_decimating_averager.sv
`timescale 1ns / 1ps
// Self-checking bench for three_axis_decimating_averager: drives sample ticks and
// register writes, predicts each per-axis sliding-window mean and checks every result.
// Depends on tda_pkg and the block itself.
module tb_three_axis_decimating_averager;

  import tda_pkg::*;

  localparam int SETTLE_CYCLES = 48;    // covers a full-window hop, plus margin
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_TICKS   = 44;

  // indexes that decode to no register
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = CFG_INDEX_BITS'(3);

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic [SAMPLE_BITS-1:0]    sample_x = '0;
  logic [SAMPLE_BITS-1:0]    sample_y = '0;
  logic [SAMPLE_BITS-1:0]    sample_z = '0;
  logic                      mean_valid;
  logic                      mean_stall = 1'b0;
  logic [SAMPLE_BITS-1:0]    mean_x;
  logic [SAMPLE_BITS-1:0]    mean_y;
  logic [SAMPLE_BITS-1:0]    mean_z;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [LEN_BITS-1:0]       cfg_data = '0;

  three_axis_decimating_averager dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .mean_valid(mean_valid), .mean_stall(mean_stall),
    .mean_x(mean_x), .mean_y(mean_y), .mean_z(mean_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  entry_t ticks_to_send[$];
  entry_t means_due[$];

  // mirror of the block state
  entry_t              hist [WINDOW_MAX];
  logic [PTR_BITS-1:0] wr_pos;
  int                  hop_cnt;
  logic [LEN_BITS-1:0] win_reg;
  logic [LEN_BITS-1:0] hop_reg;

  logic sample_took = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   fault_count = 0;
  int   quiet_cycles = 0;

  task automatic average_tick(input entry_t s);
    int          w;
    int          h;
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    logic [PTR_BITS-1:0] p;
    entry_t      m;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    h = hop_reg;
    if (h < 1) h = 1;
    if (h > w) h = w;
    hist[wr_pos] = s;
    wr_pos = wr_pos + PTR_BITS'(1);
    // a shortened hop fires at once if the count already reached it
    if (hop_cnt + 1 < h) begin
      hop_cnt = hop_cnt + 1;
    end else begin
      hop_cnt = 0;
      sx = 0;
      sy = 0;
      sz = 0;
      p = wr_pos;
      for (int i = 0; i < w; i++) begin
        p = p - PTR_BITS'(1);
        sx += hist[p].x;
        sy += hist[p].y;
        sz += hist[p].z;
      end
      m.x = SAMPLE_BITS'(sx / w);
      m.y = SAMPLE_BITS'(sy / w);
      m.z = SAMPLE_BITS'(sz / w);
      means_due.insert(means_due.size(), m);
    end
  endtask

  task automatic check_axis(input string axis, input logic [SAMPLE_BITS-1:0] want,
                            input logic [SAMPLE_BITS-1:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: mean_%s expected %0d got %0d", $time, axis, want, got);
    end
  endtask

  // monitor: prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin
    entry_t want;
    if (rst) begin
      for (int i = 0; i < WINDOW_MAX; i++) hist[i] = '0;
      wr_pos = '0;
      hop_cnt = 0;
      win_reg = WINDOW_LEN_RESET;
      hop_reg = HOP_LEN_RESET;
      sample_took = 1'b0;
    end else begin
      sample_took = sample_valid && !sample_stall;
      if (sample_took) average_tick('{x: sample_x, y: sample_y, z: sample_z});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW_LEN) win_reg = cfg_data;
        else if (cfg_index == CFG_HOP_LEN) hop_reg = cfg_data;
      end
      if (mean_valid && !mean_stall) begin
        if (means_due.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected mean expected none got %0d %0d %0d",
                   $time, mean_x, mean_y, mean_z);
        end else begin
          want = means_due[0];
          means_due.delete(0);
          check_axis("x", want.x, mean_x);
          check_axis("y", want.y, mean_y);
          check_axis("z", want.z, mean_z);
        end
      end
    end
  end

  // watchdog: no request of any kind for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (mean_valid && !mean_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample driver
  int send_gap = 0;
  always @(negedge clk) begin
    entry_t t;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_took) begin
      // stalled: hold the payload
    end else if (send_gap > 0) begin
      send_gap--;
      sample_valid <= 1'b0;
    end else if (ticks_to_send.size() == 0) begin
      sample_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(0, 16);
      sample_valid <= 1'b0;
    end else begin
      t = ticks_to_send[0];
      ticks_to_send.delete(0);
      sample_valid <= 1'b1;
      sample_x <= t.x;
      sample_y <= t.y;
      sample_z <= t.z;
    end
  end

  // result receiver
  int stall_left = 0;
  int long_left = 0;
  always @(negedge clk) begin
    if (long_left > 0) begin
      long_left--;
      mean_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      long_left = LONG_HOLD - 1;
      mean_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      mean_stall <= 1'b1;
    end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      mean_stall <= 1'b1;
    end else begin
      mean_stall <= 1'b0;
    end
  end

  task automatic push_tick(input int x, input int y, input int z);
    entry_t e;
    e.x = SAMPLE_BITS'(x);
    e.y = SAMPLE_BITS'(y);
    e.z = SAMPLE_BITS'(z);
    ticks_to_send.insert(ticks_to_send.size(), e);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= LEN_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender pause: everything sent, every mean back, block settled
  task automatic drain_block();
    while (ticks_to_send.size() != 0 || sample_valid) @(posedge clk);
    while (means_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int wv;
    int hv;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unused indexes must leave the reset settings alone
    write_reg(CFG_UNUSED_LO, 31);
    write_reg(CFG_UNUSED_HI, 0);

    // reset settings; the first windows still hold zeros
    push_tick(0, 0, 0);
    push_tick(4095, 4095, 4095);
    push_tick(12'hAAA, 12'h555, 12'hFFF);
    push_tick(12'h555, 12'hAAA, 0);
    push_tick(4095, 0, 12'h800);
    push_tick(1, 4094, 12'h7FF);
    push_tick(0, 4095, 1);
    push_tick(4095, 4095, 4095);
    drain_block();

    // zero window and hop act as one
    write_reg(CFG_WINDOW_LEN, 0);
    write_reg(CFG_HOP_LEN, 0);
    push_tick(4095, 0, 12'hAAA);
    push_tick(0, 4095, 12'h555);
    push_tick(4095, 4095, 4095);
    drain_block();

    // oversize registers clamp to the full window; then shorten the hop mid-count
    write_reg(CFG_WINDOW_LEN, 31);
    write_reg(CFG_HOP_LEN, 31);
    for (int i = 0; i < 7; i++) push_tick(4095, i * 585, 4095 - i);
    drain_block();
    write_reg(CFG_HOP_LEN, 3);
    push_tick(4095, 4095, 0);
    drain_block();

    // hop above window is clamped to the window
    write_reg(CFG_WINDOW_LEN, 4);
    write_reg(CFG_HOP_LEN, 9);
    push_tick(4095, 0, 1);
    push_tick(4095, 0, 2);
    push_tick(4095, 0, 3);
    push_tick(4095, 0, 4);
    drain_block();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin wv = 1;  hv = 1;  end
        1: begin wv = 16; hv = 1;  end
        2: begin wv = 16; hv = 16; end
        3: begin wv = 0;  hv = 31; end
        4: begin wv = 31; hv = 0;  end
        default: begin
          wv = $urandom_range(0, 31);
          hv = $urandom_range(0, 31);
        end
      endcase
      if (ph == 5) write_reg(CFG_UNUSED_HI, $urandom_range(0, 31));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_WINDOW_LEN, wv);
        write_reg(CFG_HOP_LEN, hv);
      end else begin
        write_reg(CFG_HOP_LEN, hv);
        write_reg(CFG_WINDOW_LEN, wv);
      end
      // receiver backs off long enough for the block to stall its input
      if (ph == 1) hold_req = 1'b1;
      if (ph == RANDOM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_TICKS; i++)
        push_tick(pick_sample(), pick_sample(), pick_sample());
      drain_block();
    end

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/tda_pkg.sv
design/three_axis_decimating_averager.sv
test/tb_three_axis_decimating_averager.sv
